[hw/rtl/boundary_tag_block_allocator_macros.svh]
// Assertion helpers used by the allocator top level.
`ifndef BOUNDARY_TAG_BLOCK_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define BTA_ASSERT_SAME(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the trigger.
`define BTA_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("allocator check failed");

`endif

[hw/rtl/bta_pkg.sv]
package bta_pkg;

    // Default geometry of the byte store.
    localparam int MEM_BYTES_DEF    = 65536;
    localparam int ALIGN_BYTES_DEF  = 16;
    localparam int HEADER_BYTES_DEF = 8;

    // Command codes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    // Register addresses.
    localparam logic [2:0] ADDR_FIT_POLICY = 3'd0;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALOC_WALK,
        ST_ALOC_SPLIT,
        ST_ALOC_MARK,
        ST_FREE_WALK,
        ST_FREE_MARK,
        ST_MRG_START,
        ST_MRG_HEAD,
        ST_MRG_NEXT,
        ST_MRG_WR
    } bta_state_t;

    // Control from the sequencer to the header store.
    typedef struct packed {
        logic wr_en;
        logic init;
    } mem_ctl_t;

endpackage

[hw/rtl/bta_mem.sv]
module bta_mem #(
    parameter int SLOTS  = 4096,
    parameter int SLOT_W = 12,
    parameter int SIZE_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bta_pkg::mem_ctl_t   ctl,
    input  logic [SLOT_W-1:0]   waddr,
    input  logic [SIZE_W:0]     wdata,
    input  logic [SLOT_W-1:0]   raddr,
    output logic [SIZE_W:0]     rdata
);
    import bta_pkg::*;

    logic [SIZE_W:0] mem [SLOTS];
    logic [SIZE_W:0] rdata_reg;
    logic            fresh_reg;
    logic            rfresh_reg;

    // Header array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Entry 0 reads as one whole free block after reset or a store reset until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg  <= 1'b1;
            rfresh_reg <= 1'b0;
        end
        else
        begin
            rfresh_reg <= fresh_reg && (raddr == '0);
            if (ctl.init)
            begin
                fresh_reg <= 1'b1;
            end
            else if (ctl.wr_en && (waddr == '0))
            begin
                fresh_reg <= 1'b0;
            end
        end
    end

    assign rdata = rfresh_reg ? {1'b0, SIZE_W'(SLOTS)} : rdata_reg;

endmodule

[hw/rtl/bta_seq.sv]
module bta_seq #(
    parameter int MEM_BYTES    = bta_pkg::MEM_BYTES_DEF,
    parameter int ALIGN_BYTES  = bta_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = bta_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fit_policy,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] request_bytes,
    input  logic [15:0] free_offset,
    output logic        done,
    output logic [15:0] user_offset,
    output logic        granted
);
    import bta_pkg::*;

    localparam int SLOTS   = MEM_BYTES / ALIGN_BYTES;
    localparam int LOG_A   = $clog2(ALIGN_BYTES);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SIZE_W  = $clog2(SLOTS + 1);
    localparam int CW      = (SIZE_W > 18) ? SIZE_W + 1 : 19;
    localparam int SPLIT_U = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int ADDR_W  = SLOT_W + LOG_A;

    bta_state_t        state_reg, state_next;
    logic [SIZE_W-1:0] cur_reg, cur_next;
    logic [SIZE_W-1:0] nxt_reg, nxt_next;
    logic [CW-1:0]     need_reg, need_next;
    logic [CW-1:0]     start_reg, start_next;
    logic              found_reg, found_next;
    logic [SIZE_W-1:0] best_at_reg, best_at_next;
    logic [SIZE_W-1:0] best_sz_reg, best_sz_next;
    logic              done_reg, done_next;
    logic [15:0]       uoff_reg, uoff_next;
    logic              ok_reg, ok_next;

    mem_ctl_t          mctl;
    logic [SLOT_W-1:0] waddr;
    logic [SIZE_W:0]   wdata;
    logic [SIZE_W-1:0] rd_next;
    logic [SIZE_W:0]   rdata;
    logic [SIZE_W-1:0] rd_size;
    logic              rd_used;

    logic [SIZE_W-1:0] add_a;
    logic [SIZE_W:0]   add_sum;
    logic              add_end;
    logic              fit;
    logic              better;
    logic [17:0]       need_sum;
    logic [15:0]       off_sub;
    logic              off_ok;
    logic [SIZE_W-1:0] rem;
    logic              do_split;
    logic [ADDR_W:0]   ubyte;

    bta_mem #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .SIZE_W (SIZE_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (SLOT_W'(rd_next)),
        .rdata (rdata)
    );

    assign rd_size = rdata[SIZE_W-1:0];
    assign rd_used = rdata[SIZE_W];

    // Shared chain adder: block start plus the size just read.
    assign add_a   = (state_reg == ST_MRG_NEXT) ? nxt_reg : cur_reg;
    assign add_sum = {1'b0, add_a} + {1'b0, rd_size};
    assign add_end = (add_sum >= (SIZE_W + 1)'(SLOTS)) || (rd_size == '0);

    assign fit    = !rd_used && (CW'(rd_size) >= need_reg);
    assign better = !found_reg || (rd_size < best_sz_reg);

    // Required size in alignment units; the header rides in the constant.
    assign need_sum = 18'(request_bytes) + 18'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign off_sub  = free_offset - 16'(HEADER_BYTES);
    assign off_ok   = (free_offset >= 16'(HEADER_BYTES))
                   && ((off_sub & 16'(ALIGN_BYTES - 1)) == 16'd0);

    assign rem      = best_sz_reg - SIZE_W'(need_reg);
    assign do_split = CW'(rem) >= CW'(SPLIT_U);
    assign ubyte    = {1'b0, SLOT_W'(best_at_reg), {LOG_A{1'b0}}}
                    + (ADDR_W + 1)'(HEADER_BYTES);

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        need_reg    <= need_next;
        start_reg   <= start_next;
        found_reg   <= found_next;
        best_at_reg <= best_at_next;
        best_sz_reg <= best_sz_next;
        uoff_reg    <= uoff_next;
        ok_reg      <= ok_next;
    end

    // Sequencer: walks the chain one header per cycle.
    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        need_next    = need_reg;
        start_next   = start_reg;
        found_next   = found_reg;
        best_at_next = best_at_reg;
        best_sz_next = best_sz_reg;
        done_next    = 1'b0;
        uoff_next    = uoff_reg;
        ok_next      = ok_reg;
        mctl         = '0;
        waddr        = SLOT_W'(cur_reg);
        wdata        = '0;
        rd_next      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next   = '0;
                    found_next = 1'b0;
                    need_next  = CW'(need_sum >> LOG_A);
                    start_next = CW'(off_sub >> LOG_A);
                    uoff_next  = 16'd0;
                    ok_next    = 1'b1;
                    case (mode)
                        MODE_ALLOC:
                        begin
                            state_next = ST_ALOC_WALK;
                        end
                        MODE_FREE:
                        begin
                            if (off_ok)
                            begin
                                state_next = ST_FREE_WALK;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        MODE_INIT:
                        begin
                            mctl.init = 1'b1;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            ok_next   = 1'b0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_ALOC_WALK:
            begin
                if (fit && better)
                begin
                    found_next   = 1'b1;
                    best_at_next = cur_reg;
                    best_sz_next = rd_size;
                end
                if ((fit && !fit_policy) || add_end)
                begin
                    if (fit || found_reg)
                    begin
                        state_next = ST_ALOC_SPLIT;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cur_next = SIZE_W'(add_sum);
                    rd_next  = SIZE_W'(add_sum);
                end
            end

            ST_ALOC_SPLIT:
            begin
                // The rest of a large block becomes a new free block.
                if (do_split)
                begin
                    mctl.wr_en = 1'b1;
                    waddr      = SLOT_W'(best_at_reg + SIZE_W'(need_reg));
                    wdata      = {1'b0, rem};
                end
                state_next = ST_ALOC_MARK;
            end

            ST_ALOC_MARK:
            begin
                mctl.wr_en = 1'b1;
                waddr      = SLOT_W'(best_at_reg);
                wdata      = {1'b1, do_split ? SIZE_W'(need_reg) : best_sz_reg};
                uoff_next  = 16'(ubyte);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_FREE_WALK:
            begin
                best_sz_next = rd_size;
                if (CW'(cur_reg) == start_reg)
                begin
                    state_next = ST_FREE_MARK;
                end
                else if (add_end || (CW'(cur_reg) > start_reg))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = SIZE_W'(add_sum);
                    rd_next  = SIZE_W'(add_sum);
                end
            end

            ST_FREE_MARK:
            begin
                mctl.wr_en = 1'b1;
                wdata      = {1'b0, best_sz_reg};
                state_next = ST_MRG_START;
            end

            ST_MRG_START:
            begin
                cur_next   = '0;
                state_next = ST_MRG_HEAD;
            end

            ST_MRG_HEAD:
            begin
                if (rd_size == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!rd_used)
                begin
                    nxt_next   = SIZE_W'(add_sum);
                    rd_next    = SIZE_W'(add_sum);
                    state_next = add_end ? ST_MRG_WR : ST_MRG_NEXT;
                end
                else if (add_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = SIZE_W'(add_sum);
                    rd_next  = SIZE_W'(add_sum);
                end
            end

            ST_MRG_NEXT:
            begin
                // Absorb the following block while it is free.
                if (!rd_used && (rd_size != '0))
                begin
                    nxt_next = SIZE_W'(add_sum);
                    rd_next  = SIZE_W'(add_sum);
                    if (add_end)
                    begin
                        state_next = ST_MRG_WR;
                    end
                end
                else
                begin
                    state_next = ST_MRG_WR;
                end
            end

            ST_MRG_WR:
            begin
                mctl.wr_en = 1'b1;
                wdata      = {1'b0, nxt_reg - cur_reg};
                if ({1'b0, nxt_reg} >= (SIZE_W + 1)'(SLOTS))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next   = nxt_reg;
                    rd_next    = nxt_reg;
                    state_next = ST_MRG_HEAD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign user_offset = uoff_reg;
    assign granted     = ok_reg;

endmodule

[hw/rtl/boundary_tag_block_allocator.sv]
// Boundary-tag block allocator over a byte store kept as a chain of headed blocks.
// Command channel: a word is taken at a clock edge where start is high and busy is
// low; mode selects allocate, free or store reset.
// Result channel: done is high for exactly one cycle with user_offset and granted;
// the receiver cannot stall, so results are never held back.
// Sequence: an allocate reads headers until a block fits (first fit) or the chain
// ends, writes any split remainder and marks the block, then shows its result; if
// none fits, it answers as the walk ends. A free reads headers up to its block,
// marks it free, then runs a merging pass over the chain that joins free runs.
// A store reset, an unused mode or a rejected free answers without a walk.
// Throughput is one word at a time; busy stays high until the result is shown.
// The header memory has one read and one write port, which sets the walk speed.
// Configuration: an APB port holds fit_policy at address 0 (0 first fit, 1 best).
// Reset: fit_policy clears and the store reads as one whole free block; no
// clearing pass is run, since entry 0 is overridden until first written.
module boundary_tag_block_allocator #(
    parameter int MEM_BYTES    = bta_pkg::MEM_BYTES_DEF,
    parameter int ALIGN_BYTES  = bta_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = bta_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] request_bytes,
    input  logic [15:0] free_offset,
    output logic        done,
    output logic [15:0] user_offset,
    output logic        granted
);
    import bta_pkg::*;

`include "boundary_tag_block_allocator_macros.svh"

    logic policy_reg;
    logic cfg_wr;

    // Configuration register write and read back.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr == ADDR_FIT_POLICY))
        begin
            policy_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == ADDR_FIT_POLICY) ? {31'd0, policy_reg} : 32'd0;

    bta_seq #(
        .MEM_BYTES    (MEM_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fit_policy    (policy_reg),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .done          (done),
        .user_offset   (user_offset),
        .granted       (granted)
    );

    // A result is only shown once the sequencer is back to idle.
    `BTA_ASSERT_SAME(a_done_idle, done, !busy)
    // An accepted word either starts work or answers at once.
    `BTA_ASSERT_NEXT(a_accept_acts, start && !busy, busy || done)
    // A refused allocation carries no offset.
    `BTA_ASSERT_SAME(a_refuse_zero, done && !granted, user_offset == 16'd0)

endmodule
